/* sv/boundary_tag_first_fit_allocator_macros.svh */
// assertion macros for the boundary tag allocator
// depends on nothing; taken in by the top level only
`ifndef BOUNDARY_TAG_FIRST_FIT_ALLOCATOR_MACROS_SVH
`define BOUNDARY_TAG_FIRST_FIT_ALLOCATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BTA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bta check failed");
`define BTA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bta check failed");
`else
`define BTA_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define BTA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* sv/bta_pkg.sv */
// shared types and constants of the boundary tag allocator
// used by the heap ram and the top level
package bta_pkg;
  localparam int OW = 36;                       // byte offset width with headroom
  localparam logic [31:0] TAG_MASK = 32'hFFFF_FFF8;
  localparam logic [OW-1:0] DSIZE = OW'(8);
  localparam logic [OW-1:0] MIN_BLOCK = OW'(16);

  typedef struct packed {
    logic [OW-1:0] rd_addr;
    logic          wr_en;
    logic [OW-1:0] wr_addr;
    logic [31:0]   wr_data;
  } mem_req_t;
endpackage

/* sv/bta_heap_ram.sv */
// heap word store with one write and one registered read port, byte addressed
// depends on bta_pkg; accesses outside the heap read 0 and drop writes
module bta_heap_ram import bta_pkg::*; #(
  parameter int HEAP_BYTES = 65536
) (
  input  logic        clk,
  input  mem_req_t    req,
  output logic [31:0] rd_tag
);
  localparam int HEAP_WORDS = HEAP_BYTES / 4;
  localparam int WAW = $clog2(HEAP_WORDS);

  logic [31:0] mem [HEAP_WORDS];
  logic [31:0] rd_q_r;
  logic        oor_r;
  logic        wr_in;
  logic        rd_in;

  assign wr_in = req.wr_addr < OW'(HEAP_BYTES);
  assign rd_in = req.rd_addr < OW'(HEAP_BYTES);

  always_ff @(posedge clk) begin
    if (req.wr_en && wr_in) begin
      mem[req.wr_addr[WAW+1:2]] <= req.wr_data;
    end
    rd_q_r <= mem[req.rd_addr[WAW+1:2]];
    oor_r <= !rd_in;
  end

  assign rd_tag = oor_r ? 32'd0 : rd_q_r;
endmodule

/* sv/boundary_tag_first_fit_allocator.sv */
// Heap allocator with boundary tags and first-fit search over an implicit block list.
// After reset an init pass writes all HEAP_BYTES/4 words of the heap ram, one a
// cycle, with busy high, clearing them and laying down the initial tags. A size of
// zero is answered without going busy; a release stays busy while it writes its tags
// and merges with free neighbors, and an allocate walks one header per block, then
// places the block (with more writes when it splits), growing the break first when
// no free block fits. An allocate that finds no room ends after the walk. A result
// shows for one cycle on out_valid, while busy is low, and cannot be stalled. Start
// is taken whenever busy is low.
// depends on bta_pkg, bta_heap_ram and the assertion macro header
`include "boundary_tag_first_fit_allocator_macros.svh"
module boundary_tag_first_fit_allocator import bta_pkg::*; #(
  parameter int HEAP_BYTES = 65536,
  parameter int INIT_CHUNK_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_command,
  input  logic [15:0] in_request_size,
  input  logic [15:0] in_block_addr,
  output logic        out_valid,
  output logic [15:0] out_payload_addr,
  output logic        out_status
);
  localparam int HEAP_WORDS = HEAP_BYTES / 4;
  localparam int WAW = $clog2(HEAP_WORDS);
  localparam int BW = $clog2(HEAP_BYTES + 1);
  localparam int CW = INIT_CHUNK_BYTES / 4;
  localparam int CHUNK = (CW % 2 == 1) ? (CW + 1) * 4 : CW * 4;
  localparam bit FITS = (16 + CHUNK) <= HEAP_BYTES;
  localparam int BRK_INIT = FITS ? 16 + CHUNK : 16;
  localparam int FTR_W = (16 + CHUNK - 8) / 4;
  localparam int EPI_W = (16 + CHUNK - 4) / 4;

  localparam logic [5:0] S_INIT = 6'd0,  S_IDLE = 6'd1,  S_REL0 = 6'd2,  S_REL1 = 6'd3,
                         S_REL2 = 6'd4,  S_M0 = 6'd5,    S_M1 = 6'd6,    S_M2 = 6'd7,
                         S_M3 = 6'd8,    S_M4 = 6'd9,    S_M5 = 6'd10,   S_LA0 = 6'd11,
                         S_LA1 = 6'd12,  S_LA2 = 6'd13,  S_LA3 = 6'd14,  S_RB0 = 6'd15,
                         S_RB1 = 6'd16,  S_BB0 = 6'd17,  S_BB1 = 6'd18,  S_BB2 = 6'd19,
                         S_FF0 = 6'd20,  S_FF1 = 6'd21,  S_GR0 = 6'd22,  S_GR1 = 6'd23,
                         S_GR2 = 6'd24,  S_P0 = 6'd25,   S_P1 = 6'd26,   S_P2 = 6'd27,
                         S_P3 = 6'd28,   S_P4 = 6'd29,   S_PN = 6'd30;

  logic [5:0]    state_r, state_nxt;
  logic [WAW-1:0] cnt_r, cnt_nxt;
  logic [BW-1:0] brk_r, brk_nxt;
  logic [OW-1:0] bp_r, bp_nxt, nb_r, nb_nxt, pb_r, pb_nxt;
  logic [OW-1:0] msz_r, msz_nxt, psz_r, psz_nxt, size_r, size_nxt;
  logic [OW-1:0] asize_r, asize_nxt, csize_r, csize_nxt;
  logic          pa_r, pa_nxt, grow_r, grow_nxt;
  logic          out_valid_r, out_valid_nxt, out_status_r, out_status_nxt;
  logic [15:0]   out_addr_r, out_addr_nxt;

  mem_req_t      mreq;
  logic [31:0]   rtag;
  logic [OW-1:0] rsize;
  logic          ralloc;
  logic [OW-1:0] rq, rnd, nxt_hdr;
  logic [31:0]   init_word;

  bta_heap_ram #(.HEAP_BYTES(HEAP_BYTES)) u_ram (
    .clk(clk), .req(mreq), .rd_tag(rtag)
  );

  assign rsize = OW'(rtag & TAG_MASK);
  assign ralloc = rtag[0];
  assign rq = OW'(in_request_size);
  assign rnd = (rq + OW'(7)) & ~OW'(7);
  assign nxt_hdr = bp_r + asize_r - OW'(4);

  always_comb begin
    init_word = 32'd0;
    if (cnt_r == WAW'(1) || cnt_r == WAW'(2)) begin
      init_word = 32'd9;
    end else if (cnt_r == WAW'(3)) begin
      init_word = FITS ? 32'(CHUNK) : 32'd1;
    end else if (FITS && cnt_r == WAW'(FTR_W)) begin
      init_word = 32'(CHUNK);
    end else if (FITS && cnt_r == WAW'(EPI_W)) begin
      init_word = 32'd1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    brk_nxt = brk_r;
    bp_nxt = bp_r;
    nb_nxt = nb_r;
    pb_nxt = pb_r;
    msz_nxt = msz_r;
    psz_nxt = psz_r;
    size_nxt = size_r;
    asize_nxt = asize_r;
    csize_nxt = csize_r;
    pa_nxt = pa_r;
    grow_nxt = grow_r;
    out_valid_nxt = 1'b0;
    out_status_nxt = out_status_r;
    out_addr_nxt = out_addr_r;
    mreq = '0;
    unique case (state_r)
      S_INIT: begin
        mreq.wr_en = 1'b1;
        mreq.wr_addr = OW'(cnt_r) << 2;
        mreq.wr_data = init_word;
        cnt_nxt = cnt_r + WAW'(1);
        if (cnt_r == WAW'(HEAP_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (in_command) begin
            bp_nxt = OW'(in_block_addr);
            grow_nxt = 1'b0;
            state_nxt = S_REL0;
          end else if (in_request_size == 16'd0) begin
            out_valid_nxt = 1'b1;
            out_status_nxt = 1'b1;
            out_addr_nxt = 16'd0;
          end else begin
            asize_nxt = (rq <= DSIZE) ? MIN_BLOCK : rnd + DSIZE;
            bp_nxt = DSIZE;
            grow_nxt = 1'b0;
            state_nxt = S_FF0;
          end
        end
      end
      S_REL0: begin
        mreq.rd_addr = bp_r - OW'(4);
        state_nxt = S_REL1;
      end
      S_REL1: begin
        size_nxt = rsize;
        mreq.wr_en = 1'b1;
        mreq.wr_addr = bp_r - OW'(4);
        mreq.wr_data = rsize[31:0];
        state_nxt = S_REL2;
      end
      S_REL2: begin
        mreq.wr_en = 1'b1;
        mreq.wr_addr = bp_r + size_r - DSIZE;
        mreq.wr_data = size_r[31:0];
        state_nxt = S_M0;
      end
      // merge: read own header, left footer, left header, right header
      S_M0: begin
        mreq.rd_addr = bp_r - OW'(4);
        state_nxt = S_M1;
      end
      S_M1: begin
        msz_nxt = rsize;
        mreq.rd_addr = bp_r - DSIZE;
        state_nxt = S_M2;
      end
      S_M2: begin
        pb_nxt = bp_r - rsize;
        mreq.rd_addr = bp_r - rsize - OW'(4);
        state_nxt = S_M3;
      end
      S_M3: begin
        pa_nxt = ralloc;
        psz_nxt = rsize;
        mreq.rd_addr = bp_r - OW'(4);
        state_nxt = S_M4;
      end
      S_M4: begin
        nb_nxt = bp_r + rsize;
        mreq.rd_addr = bp_r + rsize - OW'(4);
        state_nxt = S_M5;
      end
      S_M5: begin
        priority if (pa_r && ralloc) begin
          if (grow_r) begin
            state_nxt = S_P0;
          end else begin
            out_valid_nxt = 1'b1;
            out_status_nxt = 1'b0;
            out_addr_nxt = 16'd0;
            state_nxt = S_IDLE;
          end
        end else if (!pa_r && ralloc) begin
          size_nxt = msz_r + psz_r;
          mreq.wr_en = 1'b1;
          mreq.wr_addr = pb_r - OW'(4);
          mreq.wr_data = 32'(msz_r + psz_r);
          state_nxt = S_LA0;
        end else if (pa_r) begin
          size_nxt = msz_r + rsize;
          mreq.wr_en = 1'b1;
          mreq.wr_addr = bp_r - OW'(4);
          mreq.wr_data = 32'(msz_r + rsize);
          state_nxt = S_RB0;
        end else begin
          size_nxt = msz_r + psz_r + rsize;
          mreq.wr_en = 1'b1;
          mreq.wr_addr = pb_r - OW'(4);
          mreq.wr_data = 32'(msz_r + psz_r + rsize);
          state_nxt = S_BB0;
        end
      end
      S_LA0: begin
        mreq.rd_addr = bp_r - OW'(4);
        state_nxt = S_LA1;
      end
      S_LA1: begin
        mreq.wr_en = 1'b1;
        mreq.wr_addr = bp_r + rsize - DSIZE;
        mreq.wr_data = size_r[31:0];
        state_nxt = S_LA2;
      end
      S_LA2: begin
        mreq.rd_addr = bp_r - DSIZE;
        state_nxt = S_LA3;
      end
      S_LA3, S_RB1: begin
        if (state_r == S_LA3) begin
          bp_nxt = bp_r - rsize;
        end else begin
          mreq.wr_en = 1'b1;
          mreq.wr_addr = bp_r + rsize - DSIZE;
          mreq.wr_data = size_r[31:0];
        end
        if (grow_r) begin
          state_nxt = S_P0;
        end else begin
          out_valid_nxt = 1'b1;
          out_status_nxt = 1'b0;
          out_addr_nxt = 16'd0;
          state_nxt = S_IDLE;
        end
      end
      S_RB0: begin
        mreq.rd_addr = bp_r - OW'(4);
        state_nxt = S_RB1;
      end
      S_BB0: begin
        mreq.rd_addr = bp_r - OW'(4);
        state_nxt = S_BB1;
      end
      S_BB1: begin
        nb_nxt = bp_r + rsize;
        mreq.rd_addr = bp_r + rsize - OW'(4);
        state_nxt = S_BB2;
      end
      S_BB2: begin
        mreq.wr_en = 1'b1;
        mreq.wr_addr = nb_r + rsize - DSIZE;
        mreq.wr_data = size_r[31:0];
        state_nxt = S_LA2;
      end
      // first-fit walk, one header read per block
      S_FF0: begin
        mreq.rd_addr = bp_r - OW'(4);
        state_nxt = S_FF1;
      end
      S_FF1: begin
        priority if (rsize == '0) begin
          if (OW'(brk_r) + asize_r > OW'(HEAP_BYTES)) begin
            out_valid_nxt = 1'b1;
            out_status_nxt = 1'b1;
            out_addr_nxt = 16'd0;
            state_nxt = S_IDLE;
          end else begin
            bp_nxt = OW'(brk_r);
            brk_nxt = brk_r + BW'(asize_r);
            state_nxt = S_GR0;
          end
        end else if (!ralloc && rsize >= asize_r) begin
          state_nxt = S_P0;
        end else begin
          bp_nxt = bp_r + rsize;
          mreq.rd_addr = bp_r + rsize - OW'(4);
        end
      end
      S_GR0: begin
        mreq.wr_en = 1'b1;
        mreq.wr_addr = bp_r - OW'(4);
        mreq.wr_data = asize_r[31:0];
        state_nxt = S_GR1;
      end
      S_GR1: begin
        mreq.wr_en = 1'b1;
        mreq.wr_addr = bp_r + asize_r - DSIZE;
        mreq.wr_data = asize_r[31:0];
        state_nxt = S_GR2;
      end
      S_GR2: begin
        mreq.wr_en = 1'b1;
        mreq.wr_addr = nxt_hdr;
        mreq.wr_data = 32'd1;
        grow_nxt = 1'b1;
        state_nxt = S_M0;
      end
      S_P0: begin
        if (grow_r && bp_r == '0) begin
          // merged block of a grown break landed on offset zero: null word
          out_valid_nxt = 1'b1;
          out_status_nxt = 1'b1;
          out_addr_nxt = 16'd0;
          state_nxt = S_IDLE;
        end else begin
          mreq.rd_addr = bp_r - OW'(4);
          state_nxt = S_P1;
        end
      end
      S_P1: begin
        csize_nxt = rsize;
        mreq.wr_en = 1'b1;
        mreq.wr_addr = bp_r - OW'(4);
        if (rsize >= asize_r + MIN_BLOCK) begin
          mreq.wr_data = asize_r[31:0] | 32'd1;
          state_nxt = S_P2;
        end else begin
          mreq.wr_data = rsize[31:0] | 32'd1;
          state_nxt = S_PN;
        end
      end
      S_P2: begin
        mreq.wr_en = 1'b1;
        mreq.wr_addr = bp_r + asize_r - DSIZE;
        mreq.wr_data = asize_r[31:0] | 32'd1;
        state_nxt = S_P3;
      end
      S_P3: begin
        mreq.wr_en = 1'b1;
        mreq.wr_addr = nxt_hdr;
        mreq.wr_data = 32'(csize_r - asize_r);
        state_nxt = S_P4;
      end
      S_P4, S_PN: begin
        mreq.wr_en = 1'b1;
        if (state_r == S_PN) begin
          mreq.wr_addr = bp_r + csize_r - DSIZE;
          mreq.wr_data = csize_r[31:0] | 32'd1;
        end else begin
          // remainder footer; header may have fallen outside the heap
          mreq.wr_addr = (nxt_hdr < OW'(HEAP_BYTES)) ?
                         bp_r + csize_r - DSIZE : bp_r + asize_r - DSIZE;
          mreq.wr_data = 32'(csize_r - asize_r);
        end
        out_valid_nxt = 1'b1;
        out_status_nxt = 1'b0;
        out_addr_nxt = bp_r[15:0];
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      cnt_r <= '0;
      brk_r <= BW'(BRK_INIT);
      out_valid_r <= 1'b0;
      grow_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      brk_r <= brk_nxt;
      out_valid_r <= out_valid_nxt;
      grow_r <= grow_nxt;
    end
    bp_r <= bp_nxt;
    nb_r <= nb_nxt;
    pb_r <= pb_nxt;
    msz_r <= msz_nxt;
    psz_r <= psz_nxt;
    size_r <= size_nxt;
    asize_r <= asize_nxt;
    csize_r <= csize_nxt;
    pa_r <= pa_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r <= out_addr_nxt;
  end

  assign busy = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_payload_addr = out_addr_r;

  `BTA_ASSERT_SAME(a_word_when_idle, clk, rst_n, out_valid, !busy)
  `BTA_ASSERT_NEXT(a_start_moves, clk, rst_n, start && !busy, busy || out_valid)
  `BTA_ASSERT_SAME(a_null_zero, clk, rst_n, out_valid && out_status, out_payload_addr == 16'd0)
  `BTA_ASSERT_SAME(a_brk_bound, clk, rst_n, 1'b1, OW'(brk_r) <= OW'(HEAP_BYTES))
endmodule
